### sv/ilt_pkg.sv
`timescale 1ns / 1ps

package ilt_pkg;

	// character codes
	localparam logic [7:0] CH_CR     = 8'h0d;
	localparam logic [7:0] CH_LF     = 8'h0a;
	localparam logic [7:0] CH_SP     = 8'h20;
	localparam logic [7:0] CH_LBRACK = 8'h5b;
	localparam logic [7:0] CH_RBRACK = 8'h5d;
	localparam logic [7:0] CH_HASH   = 8'h23;
	localparam logic [7:0] CH_SEMI   = 8'h3b;
	localparam logic [7:0] CH_EQ     = 8'h3d;
	localparam logic [7:0] CH_QUOTE  = 8'h22;

	// command codes
	localparam logic CMD_PUSH    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	// token kinds
	localparam logic [1:0] TK_SECT = 2'd0;
	localparam logic [1:0] TK_NAME = 2'd1;
	localparam logic [1:0] TK_VAL  = 2'd2;

	// event kinds
	localparam logic [1:0] EV_CHAR = 2'd0;
	localparam logic [1:0] EV_END  = 2'd1;
	localparam logic [1:0] EV_WARN = 2'd2;

	// warning codes
	localparam logic [2:0] WARN_NONE       = 3'd0;
	localparam logic [2:0] WARN_NO_BRACKET = 3'd1;
	localparam logic [2:0] WARN_NO_VALUE   = 3'd2;
	localparam logic [2:0] WARN_LINE_END   = 3'd3;
	localparam logic [2:0] WARN_CTRL_SECT  = 3'd4;

	// parser states, one-hot
	typedef enum logic [6:0] {
		ST_IDLE   = 7'b0000001,
		ST_SECT   = 7'b0000010,
		ST_NAME   = 7'b0000100,
		ST_COMM   = 7'b0001000,
		ST_WAITV  = 7'b0010000,
		ST_VAL    = 7'b0100000,
		ST_WAITEQ = 7'b1000000
	} parse_state_t;

	// one token event
	typedef struct packed {
		logic [2:0] warning;
		logic       token_blank;
		logic [7:0] out_byte;
		logic [1:0] event_kind;
		logic [1:0] token_kind;
	} token_event_t;

	// parser state carried from byte to byte
	typedef struct packed {
		parse_state_t state;
		logic         has_chars;
	} parse_ctx_t;

endpackage

### sv/ilt_decode.sv
`timescale 1ns / 1ps

module ilt_decode (
	input  ilt_pkg::parse_ctx_t   ctx,
	input  logic                  command,
	input  logic [7:0]            in_byte,
	output ilt_pkg::parse_ctx_t   ctx_nxt,
	output logic                  emit,
	output ilt_pkg::token_event_t result
);
	import ilt_pkg::*;

	always_comb begin
		ctx_nxt = ctx;
		emit    = 1'b0;
		result  = '0;
		if (command == CMD_RESTART) begin
			ctx_nxt.state     = ST_IDLE;
			ctx_nxt.has_chars = 1'b0;
		end else if (in_byte == CH_CR || in_byte == CH_LF) begin
			// line end closes whatever is open
			ctx_nxt.state     = ST_IDLE;
			ctx_nxt.has_chars = 1'b0;
			case (ctx.state)
				ST_SECT: begin
					emit               = 1'b1;
					result.token_kind  = TK_SECT;
					result.event_kind  = EV_END;
					result.token_blank = ~ctx.has_chars;
					result.warning     = WARN_NO_BRACKET;
				end
				ST_NAME: begin
					emit               = 1'b1;
					result.token_kind  = TK_NAME;
					result.event_kind  = EV_END;
					result.token_blank = ~ctx.has_chars;
					result.warning     = WARN_NO_VALUE;
				end
				ST_WAITV: begin
					emit              = 1'b1;
					result.token_kind = TK_VAL;
					result.event_kind = EV_WARN;
					result.warning    = WARN_LINE_END;
				end
				ST_VAL: begin
					emit               = 1'b1;
					result.token_kind  = TK_VAL;
					result.event_kind  = EV_END;
					result.token_blank = ~ctx.has_chars;
				end
				default: ;
			endcase
		end else begin
			case (ctx.state)
				ST_IDLE: begin
					if (in_byte > CH_SP) begin
						if (in_byte == CH_LBRACK) begin
							ctx_nxt.state     = ST_SECT;
							ctx_nxt.has_chars = 1'b0;
						end else if (in_byte inside {CH_HASH, CH_SEMI}) begin
							ctx_nxt.state = ST_COMM;
						end else begin
							ctx_nxt.state     = ST_NAME;
							ctx_nxt.has_chars = 1'b1;
							emit              = 1'b1;
							result.token_kind = TK_NAME;
							result.event_kind = EV_CHAR;
							result.out_byte   = in_byte;
						end
					end
				end
				ST_SECT: begin
					emit              = 1'b1;
					result.token_kind = TK_SECT;
					if (in_byte == CH_RBRACK) begin
						ctx_nxt.state      = ST_IDLE;
						ctx_nxt.has_chars  = 1'b0;
						result.event_kind  = EV_END;
						result.token_blank = ~ctx.has_chars;
					end else if (in_byte < CH_SP) begin
						result.event_kind = EV_WARN;
						result.warning    = WARN_CTRL_SECT;
					end else begin
						ctx_nxt.has_chars = 1'b1;
						result.event_kind = EV_CHAR;
						result.out_byte   = in_byte;
					end
				end
				ST_NAME: begin
					emit              = 1'b1;
					result.token_kind = TK_NAME;
					if (in_byte <= CH_SP || in_byte == CH_EQ) begin
						ctx_nxt.state      = (in_byte == CH_EQ) ? ST_WAITV : ST_WAITEQ;
						ctx_nxt.has_chars  = 1'b0;
						result.event_kind  = EV_END;
						result.token_blank = ~ctx.has_chars;
					end else begin
						ctx_nxt.has_chars = 1'b1;
						result.event_kind = EV_CHAR;
						result.out_byte   = in_byte;
					end
				end
				ST_WAITEQ: begin
					if (in_byte == CH_EQ) begin
						ctx_nxt.state = ST_WAITV;
					end
				end
				ST_COMM: ;
				ST_WAITV: begin
					if (in_byte > CH_SP) begin
						ctx_nxt.state     = ST_VAL;
						ctx_nxt.has_chars = 1'b0;
						// an opening quote is swallowed
						if (in_byte != CH_QUOTE) begin
							ctx_nxt.has_chars = 1'b1;
							emit              = 1'b1;
							result.token_kind = TK_VAL;
							result.event_kind = EV_CHAR;
							result.out_byte   = in_byte;
						end
					end
				end
				ST_VAL: begin
					ctx_nxt.has_chars = 1'b1;
					emit              = 1'b1;
					result.token_kind = TK_VAL;
					result.event_kind = EV_CHAR;
					result.out_byte   = in_byte;
				end
				default: begin
					ctx_nxt.state     = ST_IDLE;
					ctx_nxt.has_chars = 1'b0;
				end
			endcase
		end
	end

endmodule

### sv/ini_line_tokenizer.sv
`timescale 1ns / 1ps

// ini_line_tokenizer: byte-serial INI text tokenizer
//
// input channel (s_*): one request per text byte. s_tdata carries the byte,
// s_tuser carries the command (0 push byte, 1 restart the parser to line
// start; a restart produces no output).
// output channel (m_*): zero or one token event per input request, in order.
// m_tuser gives token kind and event kind, m_tdata the appended character,
// the blank-token flag and the warning code.
//
// an accepted byte is held in the input register, decoded, and its event is
// registered in the result register before it shows on m_*.
// throughput: one byte per cycle while m_tready stays high; the single
// decode stage between the input register and the result register updates the
// parser state for each byte that moves on. while a finished event waits in the
// result register and m_tready is low, the input register accepts only if empty.
// when m_tready stays low, the result register holds its event, the input
// register fills, and s_tready drops until the receiver takes the event.
// reset (arst_n low) empties both registers and returns the parser to line
// start with no open token.
module ini_line_tokenizer (
	input  logic        clk,
	input  logic        arst_n,
	// input requests
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // [7:0] in_byte
	input  logic        s_tuser,   // [0] command
	// token events
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // [7:0] out_byte, [8] token_blank, [11:9] warning, rest 0
	output logic [3:0]  m_tuser    // [1:0] token_kind, [3:2] event_kind
);
	import ilt_pkg::*;

	// input register
	logic         in_valid_s1;
	logic         command_s1;
	logic [7:0]   byte_s1;

	// parser state
	parse_ctx_t   ctx_q;
	parse_ctx_t   ctx_nxt;

	// result register
	logic         out_valid_s2;
	token_event_t result_s2;

	logic         emit;
	token_event_t result;
	logic         advance;

	// the held byte moves on when the result register is free or being emptied
	assign advance  = in_valid_s1 && (!out_valid_s2 || m_tready);
	assign s_tready = !in_valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			command_s1 <= s_tuser;
			byte_s1    <= s_tdata;
		end
	end

	ilt_decode u_decode (
		.ctx     (ctx_q),
		.command (command_s1),
		.in_byte (byte_s1),
		.ctx_nxt (ctx_nxt),
		.emit    (emit),
		.result  (result)
	);

	// parser state follows each processed byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctx_q.state     <= ST_IDLE;
			ctx_q.has_chars <= 1'b0;
		end else if (advance) begin
			ctx_q <= ctx_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= emit;
		end else if (m_tready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_s2 <= result;
		end
	end

	assign m_tvalid = out_valid_s2;
	assign m_tdata  = {4'd0, result_s2.warning, result_s2.token_blank, result_s2.out_byte};
	assign m_tuser  = {result_s2.event_kind, result_s2.token_kind};

endmodule
